// ===== rtl/core/scoc_pkg.sv =====
// ============================================================================
// scoc_pkg: shared types and constants of the clock offset corrector
// Item kinds, register indexes, controller states and control/status bundles.
// ============================================================================
package scoc_pkg;

    // Field and register widths
    localparam int TIME_W   = 63;
    localparam int BIAS_W   = 64;
    localparam int WIN_W    = 48;
    localparam int RATE_W   = 30;
    localparam int KIND_W   = 2;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 48;

    // Divider geometry: 94-bit dividend, two quotient bits per cycle
    localparam int DIV_W      = 94;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_CYCLES = DIV_W / DIV_RADIX;
    localparam int CNT_W      = $clog2(DIV_CYCLES);
    localparam int LIM_W      = 31;
    localparam int MULA_W     = 32;
    localparam int MULR_W     = MULA_W + RATE_W;

    // Constants
    localparam logic [WIN_W-1:0]  ONE_SEC_NS      = 48'd1000000000;
    localparam logic [WIN_W-1:0]  WIN_RESET       = '0;
    localparam logic [RATE_W-1:0] SLEW_RESET      = '0;
    localparam logic [RATE_W-1:0] STEP_RESET      = 30'd1000000;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_SLEW   = 2'd1,
        REG_STEP   = 2'd2
    } reg_idx_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_LIM,
        ST_DIV_LIM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV_STEP,
        ST_APPLY,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic err_en;
        logic mul_lim;
        logic div_step;
        logic mul_lo;
        logic mul_hi;
        logic apply;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic win_zero;
    } stat_t;

endpackage

// ===== rtl/core/scoc_ctrl.sv =====
// ============================================================================
// scoc_ctrl: sequencer of the clock offset corrector
// Walks an update through error, limit, multiply and divide steps, and
// drives the output beat handshake.
// ============================================================================
module scoc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [scoc_pkg::KIND_W-1:0]   in_kind,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output scoc_pkg::cmd_t                cmd,
    input  scoc_pkg::stat_t               stat
);

    scoc_pkg::state_t               state_reg, state_next;
    logic [scoc_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           mvalid_reg, mvalid_next;
    logic                           cnt_last;
    logic                           out_free;

    assign cnt_last = (cnt_reg == scoc_pkg::CNT_W'(scoc_pkg::DIV_CYCLES - 1));
    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = (state_reg == scoc_pkg::ST_IDLE);
    assign m_tvalid = mvalid_reg;

    // State, counter and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= scoc_pkg::ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        unique case (state_reg)
            scoc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (in_kind == scoc_pkg::KIND_UPDATE && !stat.win_zero) begin
                        state_next = scoc_pkg::ST_ERR;
                    end else begin
                        state_next = scoc_pkg::ST_DONE;
                    end
                end
            end
            scoc_pkg::ST_ERR: begin
                cmd.err_en = 1'b1;
                state_next = scoc_pkg::ST_MUL_LIM;
            end
            scoc_pkg::ST_MUL_LIM: begin
                cmd.mul_lim = 1'b1;
                cnt_next    = '0;
                state_next  = scoc_pkg::ST_DIV_LIM;
            end
            scoc_pkg::ST_DIV_LIM: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = scoc_pkg::ST_MUL_LO;
                end
            end
            scoc_pkg::ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = scoc_pkg::ST_MUL_HI;
            end
            scoc_pkg::ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                cnt_next   = '0;
                state_next = scoc_pkg::ST_DIV_STEP;
            end
            scoc_pkg::ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = scoc_pkg::ST_APPLY;
                end
            end
            scoc_pkg::ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = scoc_pkg::ST_DONE;
            end
            scoc_pkg::ST_DONE: begin
                // hand the result to the output register once it is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = scoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scoc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/scoc_dp.sv =====
// ============================================================================
// scoc_dp: datapath of the clock offset corrector
// Config registers, bias, error saturation, shared 32x30 multiplier,
// radix-2 restoring divider (two bits per cycle) and the output register.
// ============================================================================
module scoc_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [scoc_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [scoc_pkg::CDATA_W-1:0]    cfg_data,
    input  logic [scoc_pkg::KIND_W-1:0]     in_kind,
    input  logic [scoc_pkg::TIME_W-1:0]     in_mono,
    input  logic [scoc_pkg::TIME_W-1:0]     in_wall,
    input  scoc_pkg::cmd_t                  cmd,
    output scoc_pkg::stat_t                 stat,
    output logic [scoc_pkg::BIAS_W-1:0]     out_bias,
    output logic [scoc_pkg::TIME_W-1:0]     out_adj
);

    localparam int DW = scoc_pkg::DIV_W;
    localparam int WW = scoc_pkg::WIN_W;
    localparam int BW = scoc_pkg::BIAS_W;
    localparam int TW = scoc_pkg::TIME_W;

    // Config and state
    logic [WW-1:0]                  win_reg;
    logic [scoc_pkg::RATE_W-1:0]    slew_reg;
    logic [scoc_pkg::RATE_W-1:0]    step_reg;
    logic signed [BW-1:0]           bias_reg, bias_next;

    // Item and work registers
    logic [scoc_pkg::KIND_W-1:0]    kind_reg;
    logic [TW-1:0]                  mono_reg;
    logic [TW-1:0]                  wall_reg;
    logic signed [BW-1:0]           err_reg;
    logic                           neg_reg;
    logic [BW-1:0]                  mag_reg;
    logic [scoc_pkg::LIM_W-1:0]     lim_reg;
    logic [DW-1:0]                  dq_reg;
    logic [WW-1:0]                  rem_reg;
    logic [WW-1:0]                  dvsr_reg;
    logic [BW-1:0]                  obias_reg;
    logic [TW-1:0]                  oadj_reg;

    // Combinational signals
    logic signed [BW+1:0]           e_wide;
    logic signed [BW-1:0]           e_sat;
    logic [scoc_pkg::MULA_W-1:0]    mul_a;
    logic [scoc_pkg::MULR_W-1:0]    mul_res;
    logic [WW:0]                    r1s, r2s;
    logic                           ge1, ge2;
    logic [WW-1:0]                  r1, r2;
    logic [DW-1:0]                  dq1, dq2;
    logic                           q_wide;
    logic [scoc_pkg::LIM_W-1:0]     step_mag;
    logic signed [BW:0]             sum_wide;
    logic signed [BW-1:0]           sum_sat;
    logic signed [BW:0]             adj_wide;
    logic [TW-1:0]                  adj_val;

    assign stat.win_zero = (win_reg == '0);
    assign out_bias      = obias_reg;
    assign out_adj       = oadj_reg;

    // Error wall - mono - bias, saturated to 64 bits
    always_comb begin
        e_wide = $signed({3'b000, wall_reg}) - $signed({3'b000, mono_reg})
               - $signed({{2{bias_reg[BW-1]}}, bias_reg});
        if (e_wide[BW+1:BW-1] == 3'b000 || e_wide[BW+1:BW-1] == 3'b111) begin
            e_sat = e_wide[BW-1:0];
        end else if (!e_wide[BW+1]) begin
            e_sat = {1'b0, {(BW-1){1'b1}}};
        end else begin
            e_sat = {1'b1, {(BW-1){1'b0}}};
        end
    end

    // Shared multiplier operand select
    always_comb begin
        priority if (cmd.mul_lim) begin
            mul_a = scoc_pkg::MULA_W'(slew_reg);
        end else if (cmd.mul_lo) begin
            mul_a = mag_reg[31:0];
        end else begin
            mul_a = mag_reg[63:32];
        end
    end
    assign mul_res = scoc_pkg::MULR_W'(mul_a) * scoc_pkg::MULR_W'(step_reg);

    // Two restoring divide steps
    always_comb begin
        r1s = {rem_reg, dq_reg[DW-1]};
        ge1 = (r1s >= {1'b0, dvsr_reg});
        r1  = ge1 ? WW'(r1s - {1'b0, dvsr_reg}) : r1s[WW-1:0];
        dq1 = {dq_reg[DW-2:0], ge1};
        r2s = {r1, dq1[DW-1]};
        ge2 = (r2s >= {1'b0, dvsr_reg});
        r2  = ge2 ? WW'(r2s - {1'b0, dvsr_reg}) : r2s[WW-1:0];
        dq2 = {dq1[DW-2:0], ge2};
    end

    // Quotient saturation, slew clamp and bias add
    always_comb begin
        q_wide = |dq_reg[DW-1:BW];
        if (q_wide || dq_reg[BW-1:0] > BW'(lim_reg)) begin
            step_mag = lim_reg;
        end else begin
            step_mag = dq_reg[scoc_pkg::LIM_W-1:0];
        end
        if (neg_reg) begin
            sum_wide = $signed({bias_reg[BW-1], bias_reg})
                     - $signed({{(BW+1-scoc_pkg::LIM_W){1'b0}}, step_mag});
        end else begin
            sum_wide = $signed({bias_reg[BW-1], bias_reg})
                     + $signed({{(BW+1-scoc_pkg::LIM_W){1'b0}}, step_mag});
        end
        if (sum_wide[BW] == sum_wide[BW-1]) begin
            sum_sat = sum_wide[BW-1:0];
        end else if (!sum_wide[BW]) begin
            sum_sat = {1'b0, {(BW-1){1'b1}}};
        end else begin
            sum_sat = {1'b1, {(BW-1){1'b0}}};
        end
    end

    // Adjusted time: mono + bias, floored at zero, saturated high
    always_comb begin
        adj_wide = $signed({2'b00, mono_reg}) + $signed({bias_reg[BW-1], bias_reg});
        if (adj_wide[BW]) begin
            adj_val = '0;
        end else if (adj_wide[BW-1]) begin
            adj_val = '1;
        end else begin
            adj_val = adj_wide[TW-1:0];
        end
    end

    // Bias next value
    always_comb begin
        bias_next = bias_reg;
        if (cmd.apply) begin
            bias_next = sum_sat;
        end else if (cmd.load_out && kind_reg == scoc_pkg::KIND_CLEAR) begin
            bias_next = '0;
        end
    end

    // Config registers and bias
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= scoc_pkg::WIN_RESET;
            slew_reg <= scoc_pkg::SLEW_RESET;
            step_reg <= scoc_pkg::STEP_RESET;
            bias_reg <= '0;
        end else begin
            bias_reg <= bias_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    scoc_pkg::REG_WINDOW: win_reg  <= cfg_data[WW-1:0];
                    scoc_pkg::REG_SLEW:   slew_reg <= cfg_data[scoc_pkg::RATE_W-1:0];
                    scoc_pkg::REG_STEP:   step_reg <= cfg_data[scoc_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Work registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= in_kind;
            mono_reg <= in_mono;
            wall_reg <= in_wall;
        end
        if (cmd.err_en) begin
            err_reg <= e_sat;
        end
        // limit product into the divider; error magnitude alongside
        if (cmd.mul_lim) begin
            neg_reg  <= err_reg[BW-1];
            mag_reg  <= err_reg[BW-1] ? (BW'(0) - err_reg) : err_reg;
            dq_reg   <= DW'(mul_res);
            rem_reg  <= '0;
            dvsr_reg <= scoc_pkg::ONE_SEC_NS;
        end
        if (cmd.div_step) begin
            dq_reg  <= dq2;
            rem_reg <= r2;
        end
        if (cmd.mul_lo) begin
            lim_reg <= dq_reg[scoc_pkg::LIM_W-1:0];
            dq_reg  <= DW'(mul_res);
        end
        if (cmd.mul_hi) begin
            dq_reg   <= dq_reg + {mul_res, 32'b0};
            rem_reg  <= '0;
            dvsr_reg <= win_reg;
        end
        // output register
        if (cmd.load_out) begin
            obias_reg <= (kind_reg == scoc_pkg::KIND_CLEAR) ? '0 : bias_reg;
            oadj_reg  <= (kind_reg == scoc_pkg::KIND_QUERY) ? adj_val : '0;
        end
    end

endmodule

// ===== rtl/core/slew_limited_clock_offset_corrector.sv =====
// ============================================================================
// slew_limited_clock_offset_corrector: slew-limited clock offset corrector
// Update: error, limit multiply and divide, low and high multiply, divide, apply
// and done, each divide a run of the two-bit-per-cycle divider; beats are taken
// only in idle. Query, clear, unknown kind or disabled update: idle to done.
// Output register lets a new beat enter while the last result waits.
// Synchronous reset clears bias, config to defaults, and output valid.
// ============================================================================
module slew_limited_clock_offset_corrector (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // mono_time[62:0], wall_time[125:63], zero pad
    input  logic [1:0]   s_tuser,    // kind[1:0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // bias_out[63:0], adjusted_time[126:64], zero pad
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    scoc_pkg::cmd_t                     cmd;
    scoc_pkg::stat_t                    stat;
    logic [scoc_pkg::BIAS_W-1:0]        out_bias;
    logic [scoc_pkg::TIME_W-1:0]        out_adj;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, out_adj, out_bias};

    scoc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    scoc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_mono   (s_tdata[62:0]),
        .in_wall   (s_tdata[125:63]),
        .cmd       (cmd),
        .stat      (stat),
        .out_bias  (out_bias),
        .out_adj   (out_adj)
    );

endmodule

// ===== dv/slew_limited_clock_offset_corrector_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// slew_limited_clock_offset_corrector_test: self-checking bench for the corrector
// Drives update, query, clear and reserved-kind beats under several register
// settings and flow-control mixes. A scoreboard predicts every result beat
// and compares it field by field against the block's output.
// ============================================================================
import scoc_pkg::*;

// Predicts bias and adjusted time per accepted beat, checks result beats
class bias_scoreboard;
    typedef struct packed {
        logic [BIAS_W-1:0] bias;
        logic [TIME_W-1:0] adj;
    } reading_t;

    logic [WIN_W-1:0]         window_ns;
    logic [RATE_W-1:0]        slew_rate;
    logic [RATE_W-1:0]        step_ns;
    logic signed [BIAS_W-1:0] bias;
    reading_t                 readings_due[$];
    int                       errors;

    function new();
        window_ns = WIN_RESET;
        slew_rate = SLEW_RESET;
        step_ns   = STEP_RESET;
        bias      = '0;
        errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CDATA_W-1:0] val);
        case (idx)
            REG_WINDOW: window_ns = val;
            REG_SLEW:   slew_rate = val[RATE_W-1:0];
            REG_STEP:   step_ns   = val[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // 65-bit two's complement value saturated to signed 64 bits
    function logic signed [63:0] clamp65(logic [64:0] v);
        if (v[64] != v[63])
            return v[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return v[63:0];
    endfunction

    function void apply_update(logic [TIME_W-1:0] mono, logic [TIME_W-1:0] wall);
        logic signed [63:0] gap;
        logic signed [63:0] err;
        logic signed [63:0] delta;
        logic [63:0]        mag;
        logic [63:0]        lim;
        logic [127:0]       quot;
        if (window_ns == '0)
            return;
        gap = {1'b0, wall} - {1'b0, mono};
        err = clamp65({gap[63], gap} - {bias[63], bias});
        mag = err[63] ? -err : err;
        // scaled step, magnitude cut toward zero; wider than 64 bits saturates
        quot = ({64'b0, mag} * {98'b0, step_ns}) / {80'b0, window_ns};
        mag = (quot[127:64] != '0) ? '1 : quot[63:0];
        // slew clamp per step
        lim = ({34'b0, slew_rate} * {34'b0, step_ns}) / {16'b0, ONE_SEC_NS};
        if (mag > lim)
            mag = lim;
        delta = err[63] ? -mag : mag;
        bias = clamp65({bias[63], bias} + {delta[63], delta});
    endfunction

    // mono + bias, floored at zero and saturated at the 63-bit maximum
    function logic [TIME_W-1:0] adjusted_time(logic [TIME_W-1:0] mono);
        logic [63:0] sum;
        logic [63:0] back;
        if (!bias[63]) begin
            sum = {1'b0, mono} + bias;
            return sum[63] ? '1 : sum[62:0];
        end
        back = -bias;
        return (back >= {1'b0, mono}) ? '0 : mono - back[62:0];
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] mono,
                            logic [TIME_W-1:0] wall);
        reading_t r;
        r.adj = '0;
        case (kind)
            KIND_UPDATE: apply_update(mono, wall);
            KIND_QUERY:  r.adj = adjusted_time(mono);
            KIND_CLEAR:  bias = '0;
            default: ;
        endcase
        r.bias = bias;
        readings_due.push_back(r);
    endfunction

    function void check_result(logic [127:0] beat);
        reading_t r;
        if (readings_due.size() == 0) begin
            $error("unexpected result beat: bias_out %0d", $signed(beat[63:0]));
            errors++;
            return;
        end
        r = readings_due.pop_front();
        if (beat[63:0] !== r.bias) begin
            $error("bias_out mismatch: expected %0d, actual %0d",
                   $signed(r.bias), $signed(beat[63:0]));
            errors++;
        end
        if (beat[126:64] !== r.adj) begin
            $error("adjusted_time mismatch: expected %0d, actual %0d",
                   r.adj, beat[126:64]);
            errors++;
        end
    endfunction

    function int pending();
        return readings_due.size();
    endfunction
endclass

module slew_limited_clock_offset_corrector_test;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;
    localparam logic [WIN_W-1:0]  WIN_MAX       = '1;
    localparam logic [RATE_W-1:0] BILLION       = 30'd1000000000;
    localparam int                STALL_LIMIT   = 20000;
    localparam int                PHASE_ITEMS   = 150;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [47:0]  cfg_data  = '0;

    bias_scoreboard sb;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    hold_left      = 0;

    slew_limited_clock_offset_corrector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: check accepted beats, then pick next ready
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no beat moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Random time, magnitude spread over the whole 63-bit range
    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return TIME_W'(raw >> ($urandom_range(1) ? 0 : $urandom_range(62)));
    endfunction

    // Mostly updates near the current mapping, plus queries, clears and noise
    function automatic void pick_item(output logic [KIND_W-1:0] kind,
                                      output logic [TIME_W-1:0] mono,
                                      output logic [TIME_W-1:0] wall);
        int unsigned        roll;
        logic signed [63:0] skew;
        logic signed [65:0] target;
        roll = $urandom_range(99);
        mono = rand_time();
        wall = rand_time();
        if (roll < 62) begin
            kind   = KIND_UPDATE;
            skew   = $signed({$urandom, $urandom}) >>> $urandom_range(63, 10);
            target = $signed({3'b0, mono}) + sb.bias + skew;
            if (target < 0)
                wall = '0;
            else if (target > $signed({3'b0, TIME_MAX}))
                wall = TIME_MAX;
            else
                wall = target[62:0];
        end else if (roll < 70) begin
            kind = KIND_UPDATE;
        end else if (roll < 88) begin
            kind = KIND_QUERY;
        end else if (roll < 94) begin
            kind = KIND_RESERVED;
        end else begin
            kind = KIND_CLEAR;
        end
    endfunction

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] mono,
                             input logic [TIME_W-1:0] wall);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b0, wall, mono};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(kind, mono, wall);
    endtask

    // Stop sending and wait for every outstanding result beat
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic configure(input logic [WIN_W-1:0] win, input logic [RATE_W-1:0] slew,
                             input logic [RATE_W-1:0] step_len);
        logic [CDATA_W-1:0] vals [3];
        reg_idx_t           idx [3];
        vals = '{win, {18'b0, slew}, {18'b0, step_len}};
        idx  = '{REG_WINDOW, REG_SLEW, REG_STEP};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  mono;
        logic [TIME_W-1:0]  wall;
        logic [WIN_W-1:0]   win;
        logic [RATE_W-1:0]  slew;
        logic [RATE_W-1:0]  step_len;
        int                 n;
        bit                 paused;

        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: window zero, so updates hold the bias
        send_beat(KIND_QUERY, '0, '0);
        send_beat(KIND_UPDATE, TIME_MAX, '0);
        send_beat(KIND_RESERVED, TIME_MAX, TIME_MAX);
        drain();

        // Tiny window, widest clamp: huge steps, error saturation, query edges
        configure(48'd1, BILLION, BILLION);
        send_beat(KIND_UPDATE, '0, TIME_MAX);
        send_beat(KIND_UPDATE, '0, TIME_MAX);
        send_beat(KIND_UPDATE, TIME_MAX, '0);
        send_beat(KIND_QUERY, TIME_MAX, '0);
        send_beat(KIND_QUERY, '0, TIME_MAX);
        send_beat(KIND_CLEAR, TIME_MAX, TIME_MAX);
        send_beat(KIND_UPDATE, TIME_MAX, '0);
        send_beat(KIND_QUERY, 63'd5, '0);
        send_beat(KIND_QUERY, TIME_MAX, '0);
        send_beat(KIND_UPDATE, TIME_MAX, TIME_MAX);
        send_beat(KIND_RESERVED, '0, '0);
        drain();

        // Step length zero: clamp is zero
        configure(WIN_MAX, BILLION, '0);
        send_beat(KIND_UPDATE, '0, TIME_MAX);
        drain();

        // Unclamped steps with truncation toward zero, then a clamped one
        configure(48'd3000, BILLION, 30'd1000);
        send_beat(KIND_UPDATE, 63'd1000, 63'd1500);
        send_beat(KIND_UPDATE, 63'd1000, '0);
        send_beat(KIND_UPDATE, '0, TIME_MAX);
        drain();

        // Random phases over settings and flow-control mixes
        for (int ph = 0; ph < 8; ph++) begin
            win      = WIN_W'({$urandom_range(16'hFFFF), $urandom} >> $urandom_range(47));
            slew     = RATE_W'($urandom_range(BILLION));
            step_len = RATE_W'($urandom_range(BILLION, 1));
            case (ph)
                0: begin
                    win = 48'd1000000000; slew = 30'd500000; step_len = 30'd1000000;
                end
                1: begin
                    win = WIN_MAX; slew = BILLION; step_len = BILLION;
                end
                2: begin
                    win = 48'd1; slew = BILLION; step_len = BILLION;
                end
                3: win = '0;
                4: slew = '0;
                5: step_len = '0;
                7: begin
                    win = WIN_W'($urandom_range(1000000, 1)); step_len = 30'd1;
                end
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            configure(win, slew, step_len);
            // long receiver hold-off while beats keep coming: input must back up
            if (ph == 0)
                hold_left = 700;
            n = 0;
            paused = 1'b0;
            while (n < PHASE_ITEMS) begin
                pick_item(kind, mono, wall);
                send_beat(kind, mono, wall);
                if (kind != KIND_RESERVED)
                    n++;
                if (!paused && n >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
            drain();
        end

        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
